// File: rtl/core/byte_stack_with_rotate_core_assert.svh
// Assertion macros used by the checker file of the byte stack.
`ifndef BYTE_STACK_WITH_ROTATE_CORE_ASSERT_SVH
`define BYTE_STACK_WITH_ROTATE_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BSWR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BSWR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bswr_pkg.sv
`default_nettype none

package bswr_pkg;

    // Field widths.
    localparam int CW = 6;
    localparam int DW = 8;
    localparam int FW = 3;
    localparam int KW = 2;

    // Largest capacity the stack ever honors, and defaults.
    localparam int MAX_CAP   = 32;
    localparam int DEPTH_DEF = 32;
    localparam logic [CW-1:0] CAP_RESET = 6'd32;

    // Command codes.
    typedef enum logic [FW-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_DUP   = 3'd3,
        CMD_UPR   = 3'd4,
        CMD_DOWNR = 3'd5,
        CMD_PRINT = 3'd6
    } t_cmd;

    // Result kinds.
    typedef enum logic [KW-1:0] {
        KIND_DATA  = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

endpackage

`default_nettype wire

// File: rtl/core/byte_stack_with_rotate_core.sv
`default_nettype none

// Byte stack with push, pop, peek, dup, rotate and print commands.
// Input channel: i_in_valid with i_func, i_value, i_rotate_depth; the block
// raises o_in_stall while it works on a command or holds an untaken result.
// Output channel: o_out_valid with o_kind, o_data_byte, o_last; the receiver
// stalls it with i_out_stall, and the result then holds unchanged.
// Capacity is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Steps per command, set by the single read and single write port of the
// stack memory and the sequencer that walks it one entry per cycle unless
// a stalled result holds a print: push, pop, error results finish at the
// transfer (result in the cycle after); peek: read, then S_PEEK; dup: S_DUP;
// rotate: S_CARRY, S_MOVE per moved entry, S_PUT; print: S_PRINT per entry.
// Reset (synchronous, active low) empties the stack, sets capacity to 32
// and drops any pending result. Stack contents need no clearing pass.
module byte_stack_with_rotate_core #(
    parameter int DEPTH = bswr_pkg::DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [bswr_pkg::CW-1:0] i_cfg_wr_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [bswr_pkg::FW-1:0] i_func,
    input  wire logic [bswr_pkg::DW-1:0] i_value,
    input  wire logic [bswr_pkg::CW-1:0] i_rotate_depth,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [bswr_pkg::KW-1:0]      o_kind,
    output logic [bswr_pkg::DW-1:0]      o_data_byte,
    output logic                         o_last
);

    localparam int CW = bswr_pkg::CW;
    localparam int DW = bswr_pkg::DW;
    localparam int KW = bswr_pkg::KW;
    localparam int AW = $clog2(DEPTH);
    localparam int HI = (DEPTH < bswr_pkg::MAX_CAP) ? DEPTH : bswr_pkg::MAX_CAP;
    localparam logic [CW-1:0] CAP_HI = CW'(HI);
    localparam logic [CW-1:0] ONE    = CW'(1);
    localparam logic [CW-1:0] TWO    = CW'(2);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PEEK  = 7'b0000010,
        S_DUP   = 7'b0000100,
        S_CARRY = 7'b0001000,
        S_MOVE  = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_PRINT = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_cap;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_end, n_end;
    logic              r_dir_up, n_dir_up;
    logic [DW-1:0]     r_carry, n_carry;
    logic [CW-1:0]     r_raddr, n_raddr;
    logic [DW-1:0]     r_rdata;
    logic [DW-1:0]     r_mem [DEPTH];

    logic              r_ovalid, n_ovalid;
    logic [KW-1:0]     r_okind, n_okind;
    logic [DW-1:0]     r_odata, n_odata;
    logic              r_olast, n_olast;

    logic              mem_we;
    logic [CW-1:0]     mem_wa;
    logic [DW-1:0]     mem_wd;

    logic              out_free;
    logic              in_xfer;
    logic [CW-1:0]     cap_eff;
    logic [CW-1:0]     top;
    logic [CW-1:0]     bot;
    logic [CW-1:0]     src;
    logic              load;
    logic [KW-1:0]     load_kind;
    logic [DW-1:0]     load_data;
    logic              load_last;

    // Capacity held to the range the stack supports.
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = ONE;
        end else if (r_cap > CAP_HI) begin
            cap_eff = CAP_HI;
        end else begin
            cap_eff = r_cap;
        end
    end

    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign top        = r_count - ONE;
    assign bot        = r_count - i_rotate_depth;
    assign src        = r_dir_up ? (r_ptr - ONE) : (r_ptr + ONE);

    // Command sequencer.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_end     = r_end;
        n_dir_up  = r_dir_up;
        n_carry   = r_carry;
        n_raddr   = r_raddr;
        mem_we    = 1'b0;
        mem_wa    = r_ptr;
        mem_wd    = r_rdata;
        load      = 1'b0;
        load_kind = bswr_pkg::KIND_DATA;
        load_data = '0;
        load_last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_func)
                        bswr_pkg::CMD_PUSH: begin
                            if (r_count >= cap_eff) begin
                                load      = 1'b1;
                                load_kind = bswr_pkg::KIND_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                mem_wa  = r_count;
                                mem_wd  = i_value;
                                n_count = r_count + ONE;
                            end
                        end
                        bswr_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                load      = 1'b1;
                                load_kind = bswr_pkg::KIND_EMPTY;
                            end else begin
                                n_count = top;
                            end
                        end
                        bswr_pkg::CMD_PEEK: begin
                            if (r_count == '0) begin
                                load      = 1'b1;
                                load_kind = bswr_pkg::KIND_EMPTY;
                            end else begin
                                n_raddr = top;
                                n_state = S_PEEK;
                            end
                        end
                        bswr_pkg::CMD_DUP: begin
                            if (r_count == '0) begin
                                load      = 1'b1;
                                load_kind = bswr_pkg::KIND_EMPTY;
                            end else if (r_count >= cap_eff) begin
                                load      = 1'b1;
                                load_kind = bswr_pkg::KIND_FULL;
                            end else begin
                                n_raddr = top;
                                n_state = S_DUP;
                            end
                        end
                        bswr_pkg::CMD_UPR, bswr_pkg::CMD_DOWNR: begin
                            if (i_rotate_depth >= TWO && i_rotate_depth <= r_count) begin
                                n_dir_up = (i_func == bswr_pkg::CMD_UPR);
                                n_ptr    = n_dir_up ? top : bot;
                                n_end    = n_dir_up ? bot : top;
                                n_raddr  = n_ptr;
                                n_state  = S_CARRY;
                            end
                        end
                        bswr_pkg::CMD_PRINT: begin
                            if (r_count != '0) begin
                                n_raddr = top;
                                n_ptr   = top;
                                n_state = S_PRINT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PEEK: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_data = r_rdata;
                    n_state   = S_IDLE;
                end
            end
            S_DUP: begin
                mem_we  = 1'b1;
                mem_wa  = r_count;
                n_carry = r_rdata;
                n_count = r_count + ONE;
                n_state = S_IDLE;
            end
            S_CARRY: begin
                // Byte that moves to the far end, then read the first source.
                n_carry = r_rdata;
                n_raddr = src;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                // Shift one entry toward the vacated slot per cycle.
                mem_we = 1'b1;
                if (src == r_end) begin
                    n_state = S_PUT;
                end else begin
                    n_ptr   = src;
                    n_raddr = r_dir_up ? (src - ONE) : (src + ONE);
                end
            end
            S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_end;
                mem_wd  = r_carry;
                n_state = S_IDLE;
            end
            S_PRINT: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_data = r_rdata;
                    load_last = (r_ptr == '0);
                    if (r_ptr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - ONE;
                        n_raddr = r_ptr - ONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded when free, cleared once its transfer completes.
    always_comb begin
        n_ovalid = r_ovalid;
        n_okind  = r_okind;
        n_odata  = r_odata;
        n_olast  = r_olast;
        if (out_free) begin
            n_ovalid = load;
            if (load) begin
                n_okind = load_kind;
                n_odata = load_data;
                n_olast = load_last;
            end
        end
    end

    // Stack memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(mem_wa)] <= mem_wd;
        end
        r_rdata <= r_mem[AW'(n_raddr)];
    end

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cap    <= bswr_pkg::CAP_RESET;
            r_ovalid <= 1'b0;
            r_carry  <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_carry  <= n_carry;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
        r_ptr    <= n_ptr;
        r_end    <= n_end;
        r_dir_up <= n_dir_up;
        r_raddr  <= n_raddr;
        r_okind  <= n_okind;
        r_odata  <= n_odata;
        r_olast  <= n_olast;
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_data_byte = r_odata;
    assign o_last      = r_olast;

endmodule

`default_nettype wire

// File: rtl/core/bswr_checker.sv
`default_nettype none

`include "byte_stack_with_rotate_core_assert.svh"

module bswr_checker (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_cfg_wr_en,
    input wire logic [bswr_pkg::CW-1:0] i_cfg_wr_data,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic [bswr_pkg::FW-1:0] i_func,
    input wire logic [bswr_pkg::DW-1:0] i_value,
    input wire logic [bswr_pkg::CW-1:0] i_rotate_depth,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic [bswr_pkg::KW-1:0] o_kind,
    input wire logic [bswr_pkg::DW-1:0] o_data_byte,
    input wire logic                    o_last
);

    // Reset drops any pending result.
    `BSWR_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    // Full and empty reports carry a zero byte and close their command.
    `BSWR_ASSERT(a_err_shape, i_clk, i_rst_n, o_out_valid && o_kind != bswr_pkg::KIND_DATA |-> o_data_byte == '0 && o_last, "malformed error result")

    // A stalled result holds until its transfer.
    `BSWR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind) && $stable(o_data_byte) && $stable(o_last), "stalled result changed")

    // A result waiting under a stall keeps the input stalled.
    `BSWR_ASSERT(a_in_blocked, i_clk, i_rst_n, o_out_valid && i_out_stall |-> o_in_stall, "input taken while result stalled")

endmodule

bind byte_stack_with_rotate_core bswr_checker u_bswr_checker (.*);

`default_nettype wire

// File: tb/byte_stack_with_rotate_core_checker.sv
// Watches both channels and the capacity port of the byte stack, keeps a
// shadow copy of the stack, and compares every result transfer with the
// oldest predicted result.
module byte_stack_with_rotate_core_checker
    import bswr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [CW-1:0] i_cfg_wr_data,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_stall,
    input  wire logic [FW-1:0] i_func,
    input  wire logic [DW-1:0] i_value,
    input  wire logic [CW-1:0] i_rotate_depth,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire logic [KW-1:0] i_kind,
    input  wire logic [DW-1:0] i_data_byte,
    input  wire logic          i_last,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind         kind;
        logic [DW-1:0] data;
        logic          last;
    } t_stack_result;

    // Shadow state of the stack.
    logic [DW-1:0]  shadow_stack [DEPTH];
    int             entry_count;
    logic [DW-1:0]  carry_byte;
    logic [CW-1:0]  capacity_reg;

    t_stack_result  pending_results [$];
    int             mismatch_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    // Count one mismatch and print it.
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what,
                 want, got);
    endtask

    task automatic expect_result(input t_kind kind, input logic [DW-1:0] data,
                                 input logic last);
        t_stack_result r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        pending_results.push_back(r);
    endtask

    // Apply one command to the shadow stack and queue the results it causes.
    task automatic apply_stack_cmd(input logic [FW-1:0] func, input logic [DW-1:0] val,
                                   input logic [CW-1:0] depth);
        int cap;
        int cap_hi;
        int n;
        int i;
        int emitted;
        cap_hi = (DEPTH < MAX_CAP) ? DEPTH : MAX_CAP;
        cap = int'(capacity_reg);
        if (cap < 1) cap = 1;
        if (cap > cap_hi) cap = cap_hi;
        n = int'(depth);
        case (t_cmd'(func))
            CMD_PUSH: begin
                if (entry_count >= cap) begin
                    expect_result(KIND_FULL, '0, 1'b1);
                end else if (entry_count < DEPTH) begin
                    shadow_stack[entry_count] = val;
                    entry_count++;
                end
            end
            CMD_POP: begin
                if (entry_count == 0) expect_result(KIND_EMPTY, '0, 1'b1);
                else entry_count--;
            end
            CMD_PEEK: begin
                if (entry_count == 0) expect_result(KIND_EMPTY, '0, 1'b1);
                else expect_result(KIND_DATA, shadow_stack[entry_count-1], 1'b1);
            end
            CMD_DUP: begin
                if (entry_count == 0) begin
                    expect_result(KIND_EMPTY, '0, 1'b1);
                end else if (entry_count >= cap || entry_count >= DEPTH) begin
                    expect_result(KIND_FULL, '0, 1'b1);
                end else begin
                    carry_byte = shadow_stack[entry_count-1];
                    shadow_stack[entry_count] = carry_byte;
                    entry_count++;
                end
            end
            CMD_UPR: begin
                // The top byte sinks to depth n; the ones below it move up.
                if (n >= 2 && n <= entry_count) begin
                    carry_byte = shadow_stack[entry_count-1];
                    for (i = entry_count - 1; i > entry_count - n; i--)
                        shadow_stack[i] = shadow_stack[i-1];
                    shadow_stack[entry_count-n] = carry_byte;
                end
            end
            CMD_DOWNR: begin
                // The byte at depth n rises to the top; the ones above it move down.
                if (n >= 2 && n <= entry_count) begin
                    carry_byte = shadow_stack[entry_count-n];
                    for (i = entry_count - n; i < entry_count - 1; i++)
                        shadow_stack[i] = shadow_stack[i+1];
                    shadow_stack[entry_count-1] = carry_byte;
                end
            end
            CMD_PRINT: begin
                emitted = 0;
                for (i = entry_count; i > 0 && emitted < MAX_CAP; i--) begin
                    expect_result(KIND_DATA, shadow_stack[i-1], (i == 1));
                    emitted++;
                end
            end
            default: begin
                // The unused command code leaves everything as it is.
            end
        endcase
    endtask

    // Results are checked before the command of the same edge is applied, so a
    // spurious result can never be matched against a fresh prediction.
    always @(posedge i_clk) begin
        t_stack_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) shadow_stack[k] = '0;
            entry_count = 0;
            carry_byte = '0;
            capacity_reg = CAP_RESET;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, kind", 0, i_kind);
                end else begin
                    want = pending_results.pop_front();
                    if (i_kind !== want.kind) report_mismatch("kind", want.kind, i_kind);
                    if (i_data_byte !== want.data)
                        report_mismatch("data_byte", want.data, i_data_byte);
                    if (i_last !== want.last) report_mismatch("last", want.last, i_last);
                end
            end
            if (i_cfg_wr_en) capacity_reg = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) apply_stack_cmd(i_func, i_value, i_rotate_depth);
        end
        o_pending <= pending_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// File: tb/tb_byte_stack_with_rotate_core.sv
// Stimulus and verdict for the byte stack. The checker beside the block does
// all prediction and comparison.
module tb_byte_stack_with_rotate_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bswr_pkg::*;

    localparam int  DEPTH          = 32;
    localparam int  SETTLE_CYCLES  = 40;
    localparam int  PHASE_ITEMS    = 23;
    localparam int  RESET_CYCLES   = 7;
    localparam real TIMEOUT_NS     = 5000000.0;
    localparam logic [FW-1:0] FUNC_UNUSED = 3'd7;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [CW-1:0] i_cfg_wr_data = '0;
    logic          i_in_valid = 1'b0;
    logic [FW-1:0] i_func = '0;
    logic [DW-1:0] i_value = '0;
    logic [CW-1:0] i_rotate_depth = '0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [KW-1:0] o_kind;
    logic [DW-1:0] o_data_byte;
    logic          o_last;
    int            fail_count;
    int            pending_count;

    // Sender pacing state.
    bit            valid_driven = 1'b0;
    int            burst_left = 1;

    // Receiver stall pattern state.
    int            stall_mode = 0;
    int            stall_left = 0;

    byte_stack_with_rotate_core #(.DEPTH(DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_rotate_depth (i_rotate_depth),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last)
    );

    byte_stack_with_rotate_core_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_rotate_depth (i_rotate_depth),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_kind         (o_kind),
        .i_data_byte    (o_data_byte),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver switches between no stalls, light stalls and heavy stalls.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(4, 40);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 1) == 1);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Present one command and hold it until the block takes the transfer.
    // Commands go out in bursts; a gap between bursts lowers valid.
    task automatic issue_cmd(input logic [FW-1:0] func, input logic [DW-1:0] val,
                             input logic [CW-1:0] depth);
        int gap;
        i_in_valid <= 1'b1;
        valid_driven = 1'b1;
        i_func <= func;
        i_value <= val;
        i_rotate_depth <= depth;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                valid_driven = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending, wait for every predicted result, then let a command that
    // causes no result finish its walk through the stack.
    task automatic drain_and_settle();
        if (valid_driven) begin
            i_in_valid <= 1'b0;
            valid_driven = 1'b0;
        end
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CW-1:0] cap);
        drain_and_settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= cap;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random command, weighted toward pushes so the stack fills and rotates
    // mostly use depths that the stack can honor.
    task automatic issue_random_cmd();
        int pick;
        int dsel;
        logic [FW-1:0] func;
        logic [CW-1:0] depth;
        pick = $urandom_range(0, 99);
        if (pick < 37)      func = CMD_PUSH;
        else if (pick < 52) func = CMD_POP;
        else if (pick < 60) func = CMD_PEEK;
        else if (pick < 68) func = CMD_DUP;
        else if (pick < 78) func = CMD_UPR;
        else if (pick < 88) func = CMD_DOWNR;
        else if (pick < 97) func = CMD_PRINT;
        else                func = FUNC_UNUSED;
        dsel = $urandom_range(0, 99);
        if (dsel < 65)      depth = CW'($urandom_range(2, 12));
        else if (dsel < 80) depth = CW'($urandom_range(13, 32));
        else                depth = CW'($urandom_range(0, 63));
        issue_cmd(func, DW'($urandom_range(0, 255)), depth);
    endtask

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [CW-1:0] phase_caps [8];
        phase_caps = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2, 6'd17, 6'd33, 6'd8};
        phase_caps[7] = CW'($urandom_range(1, 32));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: commands on an empty stack, including the unused code.
        issue_cmd(CMD_POP, 8'h00, 6'd0);
        issue_cmd(CMD_PEEK, 8'h00, 6'd0);
        issue_cmd(CMD_DUP, 8'h00, 6'd0);
        issue_cmd(CMD_PRINT, 8'h00, 6'd0);
        issue_cmd(CMD_UPR, 8'h00, 6'd2);
        issue_cmd(FUNC_UNUSED, 8'hFF, 6'h3F);

        // Directed: the extreme bytes, dup of 0xFF, rotates in and out of range.
        issue_cmd(CMD_PUSH, 8'h00, 6'd0);
        issue_cmd(CMD_PUSH, 8'hFF, 6'd0);
        issue_cmd(CMD_DUP, 8'h00, 6'd0);
        issue_cmd(CMD_PEEK, 8'h00, 6'd0);
        issue_cmd(CMD_PUSH, 8'hA5, 6'd0);
        issue_cmd(CMD_PUSH, 8'h5A, 6'd0);
        issue_cmd(CMD_UPR, 8'h00, 6'd3);
        issue_cmd(CMD_PRINT, 8'h00, 6'd0);
        issue_cmd(CMD_DOWNR, 8'h00, 6'd5);
        issue_cmd(CMD_UPR, 8'h00, 6'd1);
        issue_cmd(CMD_DOWNR, 8'h00, 6'd6);
        issue_cmd(CMD_UPR, 8'h00, 6'h3F);
        issue_cmd(CMD_DOWNR, 8'h00, 6'd0);
        issue_cmd(CMD_UPR, 8'h00, 6'd5);
        issue_cmd(CMD_PRINT, 8'h00, 6'd0);

        // Directed: capacity lowered below the number of entries held.
        set_capacity(6'd3);
        issue_cmd(CMD_PUSH, 8'h77, 6'd0);
        issue_cmd(CMD_DUP, 8'h00, 6'd0);
        issue_cmd(CMD_POP, 8'h00, 6'd0);
        issue_cmd(CMD_PEEK, 8'h00, 6'd0);
        issue_cmd(CMD_PRINT, 8'h00, 6'd0);

        // Random phases, each under its own capacity.
        foreach (phase_caps[p]) begin
            set_capacity(phase_caps[p]);
            repeat (PHASE_ITEMS) issue_random_cmd();
        end

        drain_and_settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
